### rtl/upd_pkg.sv
// Shared types, character codes and hex helpers for the URL percent decoder.
package upd_pkg;

    localparam int CMD_BYTES = 3;
    localparam int Q_DEPTH   = 2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] data;
        logic [1:0]                count;
        logic                      last;
    } cmd_t;

    typedef struct packed {
        logic                          full;
        logic                          empty;
        logic [$clog2(Q_DEPTH+1)-1:0]  level;
    } q_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Valid only for hex digits: letters have bit 6 set.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return c[6] ? 4'(c[3:0] + HEX_ALPHA_OFS) : c[3:0];
    endfunction

    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

### rtl/upd_front.sv
// Front end: accepts encoded bytes, tracks escape phase, builds output commands.
module upd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    output upd_pkg::cmd_t  cmd,
    output upd_pkg::phase_t phase
);
    import upd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    always_comb begin
        cmd        = '0;
        cmd.last   = in_last;
        phase_next = PH_IDLE;
        held_next  = '0;
        case (phase_reg)
            PH_PCT: begin
                if (is_hex(in_byte) && !in_last) begin
                    held_next  = in_byte;
                    phase_next = PH_DIG;
                end else begin
                    cmd.data[0] = CH_PERCENT;
                    if (in_byte == CH_PERCENT && !in_last) begin
                        cmd.count  = 2'd1;
                        phase_next = PH_PCT;
                    end else begin
                        cmd.data[1] = plain_map(in_byte);
                        cmd.count   = 2'd2;
                    end
                end
            end
            PH_DIG: begin
                if (is_hex(in_byte)) begin
                    cmd.data[0] = {hex_val(held_reg), hex_val(in_byte)};
                    cmd.count   = 2'd1;
                end else begin
                    // broken escape: '%', held digit, then the byte itself unless it opens a new escape
                    cmd.data[0] = CH_PERCENT;
                    cmd.data[1] = held_reg;
                    if (in_byte == CH_PERCENT && !in_last) begin
                        cmd.count  = 2'd2;
                        phase_next = PH_PCT;
                    end else begin
                        cmd.data[2] = plain_map(in_byte);
                        cmd.count   = 2'd3;
                    end
                end
            end
            default: begin
                if (in_byte == CH_PERCENT && !in_last) begin
                    phase_next = PH_PCT;
                end else begin
                    cmd.data[0] = plain_map(in_byte);
                    cmd.count   = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    assign phase = phase_reg;

endmodule

### rtl/upd_fifo.sv
// Short command queue between front and back ends.
module upd_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  upd_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output upd_pkg::cmd_t      head,
    output upd_pkg::q_status_t status
);
    import upd_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int LW = $clog2(Q_DEPTH + 1);

    cmd_t          mem_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(Q_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = LW'(level_reg + 1'b1);
        end else if (pop && !push) begin
            level_next = LW'(level_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (level_reg == LW'(Q_DEPTH));
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;

endmodule

### rtl/upd_back.sv
// Back end: serializes queued commands into the registered result channel.
module upd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  upd_pkg::cmd_t      head,
    input  upd_pkg::q_status_t q_status,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_out_last
);
    import upd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    assign load   = !q_status.empty && (!valid_reg || m_ready);
    assign at_end = (idx_reg == 2'(head.count - 2'd1));
    assign pop    = load && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = at_end ? 2'd0 : 2'(idx_reg + 2'd1);
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head.data[idx_reg];
            last_reg <= head.last && at_end;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_last = last_reg;

endmodule

### rtl/url_percent_decoder_top.sv
// Top level of the streaming URL percent decoder.
// One encoded byte is taken per cycle while s_ready is high. A decoded or
// passed-through byte is queued when its input item is accepted and then
// loaded into the output register. The output register emits one byte per
// cycle while m_ready is high, so the sustained rate is one input item per
// cycle while each item yields at most one byte; an item that ends a broken
// escape yields one, two or three bytes and holds the output until all are
// sent, with a two-entry command queue absorbing the difference before s_ready
// drops. An item that opens an escape from idle, or adds the first hex digit
// after a '%', yields no result. The last result of a text carries m_out_last.
module url_percent_decoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);
    import upd_pkg::*;

    cmd_t      front_cmd;
    cmd_t      q_head;
    q_status_t q_status;
    phase_t    front_phase;
    logic      accept;
    logic      push;
    logic      pop;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && (front_cmd.count != 2'd0);

    upd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .cmd     (front_cmd),
        .phase   (front_phase)
    );

    upd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (q_head),
        .status   (q_status)
    );

    upd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.level <= 2'(Q_DEPTH))
        else $error("command queue level out of range");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty command queue");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_in_last) |=> (front_phase == PH_IDLE))
        else $error("escape still pending after last item");

endmodule

### tb/testbench.sv
// Self-checking testbench for the streaming URL percent decoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_byte_t;

    logic       aclk;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       s_in_last  = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    text_byte_t enc_pending_q[$];
    text_byte_t decoded_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic pressure_on  = 1'b0;
    logic recv_hold    = 1'b0;

    int fail_count  = 0;
    int bytes_in    = 0;
    int bytes_out   = 0;
    int texts_sent  = 0;
    int stall_count = 0;

    phase_t     dec_phase = PH_IDLE;
    logic [7:0] dec_held  = 8'h00;
    text_byte_t step_res[0:2];
    int         step_n;

    string hex_chars = "0123456789ABCDEFabcdef";

    url_percent_decoder_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h61) v = c - 8'h57;
        else v = c - 8'h37;
        return v[3:0];
    endfunction

    task automatic put_decoded(input logic [7:0] b);
        step_res[step_n] = '{data: b, last: 1'b0};
        step_n++;
    endtask

    task automatic plain_byte(input logic [7:0] b, input logic l);
        if (b == CH_PERCENT) begin
            if (l) put_decoded(CH_PERCENT);
            else dec_phase = PH_PCT;
        end else if (b == CH_PLUS) begin
            put_decoded(CH_SPACE);
        end else begin
            put_decoded(b);
        end
    endtask

    // Expected decoded bytes for one accepted encoded item.
    task automatic decode_item(input logic [7:0] b, input logic l);
        phase_t ph;
        ph = dec_phase;
        step_n = 0;
        dec_phase = PH_IDLE;
        case (ph)
            PH_PCT: begin
                if (is_hex_digit(b) && !l) begin
                    dec_held = b;
                    dec_phase = PH_DIG;
                end else begin
                    put_decoded(CH_PERCENT);
                    plain_byte(b, l);
                end
            end
            PH_DIG: begin
                if (is_hex_digit(b)) begin
                    put_decoded({digit_value(dec_held), digit_value(b)});
                end else begin
                    put_decoded(CH_PERCENT);
                    plain_byte(dec_held, 1'b1);
                    plain_byte(b, l);
                end
                dec_held = 8'h00;
            end
            default: plain_byte(b, l);
        endcase
        if (l) begin
            if (step_n > 0) step_res[step_n-1].last = 1'b1;
            dec_phase = PH_IDLE;
            dec_held = 8'h00;
        end
        for (int i = 0; i < step_n; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
    endtask

    task automatic note_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("%s", msg);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic l);
        enc_pending_q.insert(enc_pending_q.size(), '{data: b, last: l});
        if (l) texts_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_hex();
        return hex_chars[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_hex_digit(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Random texts: plain bytes, escapes and plus signs, with some broken escapes.
    task automatic gen_texts(input int n_bytes, input int broken_pct);
        logic [7:0] txt[$];
        int made;
        int ntok;
        int k;
        made = 0;
        while (made < n_bytes) begin
            txt.delete();
            ntok = $urandom_range(1, 8);
            repeat (ntok) begin
                if ($urandom_range(0, 99) < broken_pct) begin
                    txt.insert(txt.size(), CH_PERCENT);
                    case ($urandom_range(0, 3))
                        0: txt.insert(txt.size(), rand_non_hex());
                        1: begin
                            txt.insert(txt.size(), rand_hex());
                            txt.insert(txt.size(), rand_non_hex());
                        end
                        2: begin
                            txt.insert(txt.size(), rand_hex());
                            txt.insert(txt.size(), CH_PERCENT);
                        end
                        default: txt.insert(txt.size(), CH_PERCENT);
                    endcase
                end else begin
                    k = $urandom_range(0, 9);
                    if (k < 4) begin
                        txt.insert(txt.size(), CH_PERCENT);
                        txt.insert(txt.size(), rand_hex());
                        txt.insert(txt.size(), rand_hex());
                    end else if (k == 4) begin
                        txt.insert(txt.size(), CH_PLUS);
                    end else begin
                        txt.insert(txt.size(), 8'($urandom_range(0, 255)));
                    end
                end
            end
            k = $urandom_range(0, 9);
            if (k == 0) begin
                txt.insert(txt.size(), CH_PERCENT);
            end else if (k == 1) begin
                txt.insert(txt.size(), CH_PERCENT);
                txt.insert(txt.size(), rand_hex());
            end
            for (int i = 0; i < txt.size(); i++) push_byte(txt[i], i == txt.size() - 1);
            made += txt.size();
        end
    endtask

    always @(posedge aclk) begin : drive
        text_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (enc_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = enc_pending_q.pop_front();
                s_valid   <= 1'b1;
                s_in_byte <= nxt.data;
                s_in_last <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (recv_hold) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        wait (pressure_on);
        @(posedge aclk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        recv_hold <= 1'b0;
    end

    always @(posedge aclk) begin : monitor
        text_byte_t exp_item;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_item(s_in_byte, s_in_last);
                bytes_in++;
                if (recv_hold) stall_count++;
            end
            if (m_valid && m_ready) begin
                bytes_out++;
                if (decoded_q.size() == 0) begin
                    note_error($sformatf("unexpected item: byte %02h last %0b",
                                         m_out_byte, m_out_last));
                end else begin
                    exp_item = decoded_q.pop_front();
                    if (m_out_byte !== exp_item.data || m_out_last !== exp_item.last)
                        note_error($sformatf(
                            "mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                            exp_item.data, exp_item.last, m_out_byte, m_out_last));
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int quiet;
        if (!aresetn) begin
            quiet = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic drain_pending();
        while (enc_pending_q.size() != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // directed: hex extremes, both letter cases, plus, zero byte, broken and cut escapes
        push_text("%fF+");
        push_text("%00");
        push_text("%9A");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_text("%Gx");
        push_text("%4%41");
        push_text("%");
        push_text("%7");
        push_text("%7%");
        drain_pending();

        gen_texts(28, 15);
        drain_pending();

        send_idle_pct = 67;
        gen_texts(28, 15);
        drain_pending();

        send_idle_pct  = 0;
        recv_stall_pct = 67;
        gen_texts(28, 15);
        drain_pending();

        send_idle_pct  = 11;
        recv_stall_pct = 11;
        gen_texts(28, 15);
        drain_pending();

        // long output stall with broken escapes so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gen_texts(28, 60);
        pressure_on = 1'b1;
        drain_pending();

        while (s_valid || decoded_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (decoded_q.size() != 0) note_error("decoded bytes still expected at end");
        $display("Sent %0d encoded bytes in %0d texts, checked %0d decoded bytes.",
                 bytes_in, texts_sent, bytes_out);
        $display("Idling profiles: none, sender, receiver, both; %0d items taken %s %0d.",
                 stall_count, "in a stall of", HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
